>>> rtl/rset_pkg.sv
// Package with the shared constants, codes and payload types of the raster scan tracker.
`default_nettype none
package rset_pkg;

  localparam int unsigned PAN_MOVES_PER_ROW_DEF = 10;
  localparam int unsigned ROW_COUNT_DEF         = 6;

  localparam int unsigned STEP_W  = 6;
  localparam int unsigned ANGLE_W = 8;
  localparam int unsigned LEVEL_W = 16;
  localparam int unsigned CFG_W   = 8;

  localparam logic [STEP_W-1:0]  STEP_RESET  = STEP_W'(18);
  localparam logic [ANGLE_W-1:0] LIMIT_RESET = ANGLE_W'(180);
  localparam logic [LEVEL_W-1:0] LEVEL_MAX   = '1;

  typedef enum logic [1:0] {
    OP_START  = 2'd0,
    OP_TICK   = 2'd1,
    OP_SAMPLE = 2'd2,
    OP_CANCEL = 2'd3
  } op_t;

  typedef enum logic {
    REG_STEP  = 1'b0,
    REG_LIMIT = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic [1:0]         operation;
    logic [LEVEL_W-1:0] light_level;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         scan_state;
    logic [ANGLE_W-1:0] pan_angle;
    logic [ANGLE_W-1:0] tilt_angle;
    logic [LEVEL_W-1:0] min_level;
    logic [ANGLE_W-1:0] min_pan;
    logic [ANGLE_W-1:0] min_tilt;
    logic [LEVEL_W-1:0] max_level;
    logic [ANGLE_W-1:0] max_pan;
    logic [ANGLE_W-1:0] max_tilt;
  } out_item_t;

endpackage
`default_nettype wire

>>> rtl/rset_if.sv
// Valid/ready channel interfaces for the input items and the result items.
`default_nettype none
interface rset_in_if
  import rset_pkg::*;
  ();
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface rset_out_if
  import rset_pkg::*;
  ();
  logic      valid;
  logic      ready;
  out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

>>> rtl/raster_scan_extremum_tracker.sv
// Serpentine pan/tilt scan sequencer with running light minimum and maximum tracking.
//
// Usage: operations arrive on in_ch (start, tick, sample, cancel) with a light level
// that only a sample uses. Every transfer on in_ch yields exactly one transfer on
// out_ch that shows the scan state, the servo angles and both extremes after the
// operation. The state update happens at the input transfer and the result is held
// in an output register that shows it on out_ch in the next cycle. One item is taken every cycle
// (in_ch.ready stays high while the output register is empty or being drained);
// the single update stage, a move counter plus clamped step paths for the angles and
// two level compares, sets that figure. When out_ch.ready is low with a result
// pending, in_ch.ready drops and the pending result is held. The cfg_ port writes
// the step size (index 0) and the angle limit (index 1) at any edge with cfg_we high.
// Reset, synchronous on rst_n low, gives idle state, zero angles, minimum 65535,
// maximum 0, step size 18 and angle limit 180, with no result pending.
`default_nettype none
module raster_scan_extremum_tracker
  import rset_pkg::*;
#(
  parameter int unsigned PAN_MOVES_PER_ROW = PAN_MOVES_PER_ROW_DEF,
  parameter int unsigned ROW_COUNT         = ROW_COUNT_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  rset_in_if.sink               in_ch,
  rset_out_if.source            out_ch,
  input  wire logic             cfg_we,
  input  wire logic             cfg_index,
  input  wire logic [CFG_W-1:0] cfg_wdata
);

  localparam int unsigned COL_W = $clog2(PAN_MOVES_PER_ROW + 1);
  localparam int unsigned ROW_W = $clog2(ROW_COUNT + 1);
  localparam logic [COL_W-1:0] COL_TILT = COL_W'(PAN_MOVES_PER_ROW);
  localparam logic [COL_W-1:0] COL_LAST = COL_W'(PAN_MOVES_PER_ROW - 1);
  localparam logic [ROW_W-1:0] ROW_LAST = ROW_W'(ROW_COUNT - 1);

  typedef enum logic [1:0] {
    MODE_IDLE      = 2'd0,
    MODE_BUSY      = 2'd1,
    MODE_DONE      = 2'd2,
    MODE_CANCELLED = 2'd3
  } mode_t;

  logic [STEP_W-1:0]  step_r;
  logic [ANGLE_W-1:0] limit_r;

  mode_t              mode_r, mode_nxt;
  logic [COL_W-1:0]   col_r, col_nxt;
  logic [ROW_W-1:0]   row_r, row_nxt;
  logic [ANGLE_W-1:0] pan_r, pan_nxt;
  logic [ANGLE_W-1:0] tilt_r, tilt_nxt;
  logic [LEVEL_W-1:0] lo_lvl_r, lo_lvl_nxt;
  logic [ANGLE_W-1:0] lo_pan_r, lo_pan_nxt;
  logic [ANGLE_W-1:0] lo_tilt_r, lo_tilt_nxt;
  logic [LEVEL_W-1:0] hi_lvl_r, hi_lvl_nxt;
  logic [ANGLE_W-1:0] hi_pan_r, hi_pan_nxt;
  logic [ANGLE_W-1:0] hi_tilt_r, hi_tilt_nxt;

  logic               out_valid_r;
  out_item_t          out_data_r, out_data_nxt;

  logic               in_acc;
  op_t                op;
  logic               move_en;
  logic [COL_W-1:0]   mv_col;
  logic [ROW_W-1:0]   mv_row;
  logic               is_tilt;
  logic [ANGLE_W:0]   pan_up_sum, tilt_up_sum;
  logic [ANGLE_W-1:0] pan_up, tilt_up, pan_dn, pan_dn_raw;

  assign in_ch.ready  = !out_valid_r || out_ch.ready;
  assign in_acc       = in_ch.valid && in_ch.ready;
  assign op           = op_t'(in_ch.data.operation);
  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_data_r;

  // A start restarts the move sequence from the first move of the first row.
  assign mv_col  = (op == OP_START) ? '0 : col_r;
  assign mv_row  = (op == OP_START) ? '0 : row_r;
  assign is_tilt = (mv_col == COL_TILT);
  assign move_en = (op == OP_START) || ((op == OP_TICK) && (mode_r == MODE_BUSY));

  assign pan_up_sum  = {1'b0, pan_r} + {{(ANGLE_W + 1 - STEP_W){1'b0}}, step_r};
  assign tilt_up_sum = {1'b0, tilt_r} + {{(ANGLE_W + 1 - STEP_W){1'b0}}, step_r};
  assign pan_up  = (pan_up_sum > {1'b0, limit_r}) ? limit_r : pan_up_sum[ANGLE_W-1:0];
  assign tilt_up = (tilt_up_sum > {1'b0, limit_r}) ? limit_r : tilt_up_sum[ANGLE_W-1:0];
  assign pan_dn_raw = (pan_r < ANGLE_W'(step_r)) ? '0 : pan_r - ANGLE_W'(step_r);
  assign pan_dn     = (pan_dn_raw > limit_r) ? limit_r : pan_dn_raw;

  always_comb begin
    mode_nxt    = mode_r;
    col_nxt     = col_r;
    row_nxt     = row_r;
    pan_nxt     = pan_r;
    tilt_nxt    = tilt_r;
    lo_lvl_nxt  = lo_lvl_r;
    lo_pan_nxt  = lo_pan_r;
    lo_tilt_nxt = lo_tilt_r;
    hi_lvl_nxt  = hi_lvl_r;
    hi_pan_nxt  = hi_pan_r;
    hi_tilt_nxt = hi_tilt_r;

    case (op)
      OP_START: begin
        lo_lvl_nxt  = LEVEL_MAX;
        lo_pan_nxt  = '0;
        lo_tilt_nxt = '0;
        hi_lvl_nxt  = '0;
        hi_pan_nxt  = '0;
        hi_tilt_nxt = '0;
        mode_nxt    = MODE_BUSY;
      end
      OP_SAMPLE: begin
        if (in_ch.data.light_level < lo_lvl_r) begin
          lo_lvl_nxt  = in_ch.data.light_level;
          lo_pan_nxt  = pan_r;
          lo_tilt_nxt = tilt_r;
        end
        if (in_ch.data.light_level > hi_lvl_r) begin
          hi_lvl_nxt  = in_ch.data.light_level;
          hi_pan_nxt  = pan_r;
          hi_tilt_nxt = tilt_r;
        end
      end
      OP_CANCEL: begin
        mode_nxt = MODE_CANCELLED;
        col_nxt  = '0;
        row_nxt  = '0;
      end
      default: begin
      end
    endcase

    if (move_en) begin
      if (is_tilt) begin
        tilt_nxt = tilt_up;
      end else if (!mv_row[0]) begin
        pan_nxt = pan_up;
      end else begin
        pan_nxt = pan_dn;
      end
      if ((mv_row == ROW_LAST) && (mv_col == COL_LAST)) begin
        mode_nxt = MODE_DONE;
        col_nxt  = '0;
        row_nxt  = '0;
      end else if (is_tilt) begin
        col_nxt = '0;
        row_nxt = mv_row + ROW_W'(1);
      end else begin
        col_nxt = mv_col + COL_W'(1);
        row_nxt = mv_row;
      end
    end

    out_data_nxt.scan_state = mode_nxt;
    out_data_nxt.pan_angle  = pan_nxt;
    out_data_nxt.tilt_angle = tilt_nxt;
    out_data_nxt.min_level  = lo_lvl_nxt;
    out_data_nxt.min_pan    = lo_pan_nxt;
    out_data_nxt.min_tilt   = lo_tilt_nxt;
    out_data_nxt.max_level  = hi_lvl_nxt;
    out_data_nxt.max_pan    = hi_pan_nxt;
    out_data_nxt.max_tilt   = hi_tilt_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r      <= STEP_RESET;
      limit_r     <= LIMIT_RESET;
      mode_r      <= MODE_IDLE;
      col_r       <= '0;
      row_r       <= '0;
      pan_r       <= '0;
      tilt_r      <= '0;
      lo_lvl_r    <= LEVEL_MAX;
      lo_pan_r    <= '0;
      lo_tilt_r   <= '0;
      hi_lvl_r    <= '0;
      hi_pan_r    <= '0;
      hi_tilt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_reg_t'(cfg_index))
          REG_STEP:  step_r  <= cfg_wdata[STEP_W-1:0];
          REG_LIMIT: limit_r <= cfg_wdata[ANGLE_W-1:0];
          default: begin
          end
        endcase
      end
      if (in_acc) begin
        mode_r      <= mode_nxt;
        col_r       <= col_nxt;
        row_r       <= row_nxt;
        pan_r       <= pan_nxt;
        tilt_r      <= tilt_nxt;
        lo_lvl_r    <= lo_lvl_nxt;
        lo_pan_r    <= lo_pan_nxt;
        lo_tilt_r   <= lo_tilt_nxt;
        hi_lvl_r    <= hi_lvl_nxt;
        hi_pan_r    <= hi_pan_nxt;
        hi_tilt_r   <= hi_tilt_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      out_data_r <= out_data_nxt;
    end
  end

  a_acc_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> out_valid_r)
    else $error("accepted item produced no result");

  a_counter_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (mode_r != MODE_BUSY) |-> (col_r == '0) && (row_r == '0))
    else $error("move counter not cleared outside a scan");

  a_counter_range: assert property (@(posedge clk) disable iff (!rst_n)
    (col_r <= COL_TILT) && (row_r <= ROW_LAST))
    else $error("move counter out of range");

  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && (op == OP_START)) |=>
      (out_data_r.scan_state == MODE_BUSY) || (out_data_r.scan_state == MODE_DONE))
    else $error("start did not enter a scan");

  a_result_matches_state: assert property (@(posedge clk) disable iff (!rst_n)
    $past(in_acc) |-> (out_data_r.pan_angle == pan_r) && (out_data_r.min_level == lo_lvl_r))
    else $error("result register disagrees with tracker state");

endmodule
`default_nettype wire

>>> tb/tb_top.sv
// Self-checking testbench for the raster scan tracker with directed and random operations.
`default_nettype none
module tb_top;
  import rset_pkg::*;

  localparam logic [1:0] ST_IDLE      = 2'd0;
  localparam logic [1:0] ST_BUSY      = 2'd1;
  localparam logic [1:0] ST_DONE      = 2'd2;
  localparam logic [1:0] ST_CANCELLED = 2'd3;

  localparam int unsigned MOVES_PER_SCAN =
    ROW_COUNT_DEF * PAN_MOVES_PER_ROW_DEF + ROW_COUNT_DEF - 1;
  localparam int unsigned PHASE_ITEMS = 90;
  localparam int unsigned PHASE_COUNT = 10;

  logic             clk;
  logic             rst_n;
  logic             cfg_we;
  logic             cfg_index;
  logic [CFG_W-1:0] cfg_wdata;

  rset_in_if  in_ch ();
  rset_out_if out_ch ();

  raster_scan_extremum_tracker u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  logic [STEP_W-1:0]  step_deg;
  logic [ANGLE_W-1:0] angle_max;
  logic [1:0]         s_mode;
  logic [9:0]         s_move;
  logic [ANGLE_W-1:0] s_pan;
  logic [ANGLE_W-1:0] s_tilt;
  logic [LEVEL_W-1:0] s_lo_level;
  logic [ANGLE_W-1:0] s_lo_pan;
  logic [ANGLE_W-1:0] s_lo_tilt;
  logic [LEVEL_W-1:0] s_hi_level;
  logic [ANGLE_W-1:0] s_hi_pan;
  logic [ANGLE_W-1:0] s_hi_tilt;

  out_item_t   pending_results[$];
  int unsigned fail_count;
  int unsigned items_sent;
  int unsigned tx_burst_left;
  bit          tx_idle_off;
  bit          rx_stall_off;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic logic [ANGLE_W-1:0] angle_up(logic [ANGLE_W-1:0] a);
    int unsigned sum;
    sum = a + step_deg;
    return (sum > angle_max) ? angle_max : ANGLE_W'(sum);
  endfunction

  function automatic void advance_scan();
    int unsigned row;
    int unsigned col;
    logic [ANGLE_W-1:0] lowered;
    row = s_move / (PAN_MOVES_PER_ROW_DEF + 1);
    col = s_move % (PAN_MOVES_PER_ROW_DEF + 1);
    if (col == PAN_MOVES_PER_ROW_DEF) begin
      s_tilt = angle_up(s_tilt);
    end else if (row % 2 == 0) begin
      s_pan = angle_up(s_pan);
    end else begin
      lowered = (s_pan < step_deg) ? '0 : s_pan - step_deg;
      s_pan = (lowered > angle_max) ? angle_max : lowered;
    end
    s_move = s_move + 10'd1;
    if (s_move >= MOVES_PER_SCAN) begin
      s_move = '0;
      s_mode = ST_DONE;
    end
  endfunction

  function automatic out_item_t scan_response(op_t op, logic [LEVEL_W-1:0] lvl);
    out_item_t r;
    case (op)
      OP_START: begin
        s_lo_level = LEVEL_MAX;
        s_lo_pan   = '0;
        s_lo_tilt  = '0;
        s_hi_level = '0;
        s_hi_pan   = '0;
        s_hi_tilt  = '0;
        s_mode     = ST_BUSY;
        s_move     = '0;
        advance_scan();
      end
      OP_TICK: begin
        if (s_mode == ST_BUSY) advance_scan();
      end
      OP_SAMPLE: begin
        if (lvl < s_lo_level) begin
          s_lo_level = lvl;
          s_lo_pan   = s_pan;
          s_lo_tilt  = s_tilt;
        end
        if (lvl > s_hi_level) begin
          s_hi_level = lvl;
          s_hi_pan   = s_pan;
          s_hi_tilt  = s_tilt;
        end
      end
      default: begin
        s_mode = ST_CANCELLED;
        s_move = '0;
      end
    endcase
    r.scan_state = s_mode;
    r.pan_angle  = s_pan;
    r.tilt_angle = s_tilt;
    r.min_level  = s_lo_level;
    r.min_pan    = s_lo_pan;
    r.min_tilt   = s_lo_tilt;
    r.max_level  = s_hi_level;
    r.max_pan    = s_hi_pan;
    r.max_tilt   = s_hi_tilt;
    return r;
  endfunction

  function automatic logic [LEVEL_W-1:0] pick_level();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return LEVEL_MAX;
      2: return s_lo_level;
      3: return s_hi_level;
      default: return LEVEL_W'($urandom);
    endcase
  endfunction

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s expected %0d actual %0d", name, want, got);
      fail_count++;
    end
  endfunction

  task automatic send_item(op_t op, logic [LEVEL_W-1:0] lvl);
    int unsigned gap;
    in_item_t    item;
    if (!tx_idle_off && tx_burst_left == 0) begin
      gap = $urandom_range(0, 10);
      if (gap != 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      tx_burst_left = $urandom_range(1, 24);
    end
    if (tx_burst_left != 0) tx_burst_left--;
    item.operation   = op;
    item.light_level = lvl;
    in_ch.valid <= 1'b1;
    in_ch.data  <= item;
    do @(posedge clk); while (!in_ch.ready);
    pending_results.push_back(scan_response(op, lvl));
    items_sent++;
  endtask

  task automatic wait_results();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    @(posedge clk);
  endtask

  task automatic write_config(logic [CFG_W-1:0] step_word, logic [CFG_W-1:0] limit_word);
    cfg_we    <= 1'b1;
    cfg_index <= REG_STEP;
    cfg_wdata <= step_word;
    @(posedge clk);
    step_deg = step_word[STEP_W-1:0];
    cfg_index <= REG_LIMIT;
    cfg_wdata <= limit_word;
    @(posedge clk);
    angle_max = limit_word;
    cfg_we <= 1'b0;
  endtask

  task automatic test_idle_ops();
    send_item(OP_TICK, 16'h1234);
    send_item(OP_SAMPLE, LEVEL_MAX);
    send_item(OP_SAMPLE, '0);
    send_item(OP_SAMPLE, '0);
    send_item(OP_CANCEL, 16'hA5A5);
    send_item(OP_TICK, '0);
  endtask

  task automatic test_restart_and_cancel();
    send_item(OP_START, 16'h5A5A);
    send_item(OP_SAMPLE, 16'd1234);
    send_item(OP_SAMPLE, 16'd1234);
    send_item(OP_TICK, '0);
    send_item(OP_SAMPLE, LEVEL_MAX);
    send_item(OP_CANCEL, '0);
    send_item(OP_TICK, '0);
    send_item(OP_START, LEVEL_MAX);
    send_item(OP_SAMPLE, '0);
  endtask

  task automatic test_angle_saturation();
    wait_results();
    write_config(8'hFF, 8'hFF);
    send_item(OP_START, '0);
    repeat (4) send_item(OP_TICK, '0);
    wait_results();
    // A lowered limit pulls the parked angle down even with a zero step.
    write_config(8'h00, 8'd5);
    send_item(OP_TICK, '0);
    send_item(OP_TICK, '0);
    wait_results();
    write_config(8'hC7, 8'd0);
    send_item(OP_TICK, '0);
  endtask

  task automatic test_random_scans();
    int unsigned target;
    int unsigned r;
    for (int phase = 0; phase < PHASE_COUNT; phase++) begin
      wait_results();
      case (phase)
        0: write_config(8'd18, 8'd180);
        1: write_config(8'd1, 8'd255);
        2: write_config(8'd45, 8'd0);
        3: write_config(8'hFF, 8'd255);
        4: write_config(CFG_W'($urandom), CFG_W'($urandom));
        5: write_config(8'h40, CFG_W'($urandom));
        default: write_config(CFG_W'($urandom_range(1, 45)), CFG_W'($urandom));
      endcase
      tx_idle_off  = (phase == 1);
      rx_stall_off = (phase == 1);
      target = items_sent + PHASE_ITEMS;
      while (items_sent < target) begin
        if ($urandom_range(0, 99) < 85) begin
          send_item(OP_START, LEVEL_W'($urandom));
          while (s_mode == ST_BUSY) begin
            r = $urandom_range(0, 999);
            if (r < 3) send_item(OP_CANCEL, LEVEL_W'($urandom));
            else if (r < 6) send_item(OP_START, LEVEL_W'($urandom));
            else send_item(OP_TICK, LEVEL_W'($urandom));
            if ($urandom_range(0, 1) == 1) send_item(OP_SAMPLE, pick_level());
          end
          repeat ($urandom_range(0, 2)) send_item(OP_TICK, '0);
        end else begin
          repeat ($urandom_range(1, 5)) send_item(op_t'($urandom_range(0, 3)), pick_level());
          if ($urandom_range(0, 3) == 0) wait_results();
        end
      end
    end
    tx_idle_off  = 1'b0;
    rx_stall_off = 1'b0;
  endtask

  initial begin
    int unsigned run_left;
    logic        rx_level;
    run_left = 0;
    rx_level = 1'b0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rx_stall_off) begin
        out_ch.ready <= 1'b1;
      end else begin
        if (run_left == 0) begin
          rx_level = ($urandom_range(0, 99) < 65);
          run_left = rx_level ? $urandom_range(1, 30) : $urandom_range(1, 12);
        end
        run_left--;
        out_ch.ready <= rx_level;
      end
    end
  end

  // Every result transfer is matched against the oldest prediction.
  always @(posedge clk) begin
    out_item_t want;
    out_item_t got;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got = out_ch.data;
      if (pending_results.size() == 0) begin
        $error("result transfer with no expected result pending");
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        check_field("scan_state", want.scan_state, got.scan_state);
        check_field("pan_angle", want.pan_angle, got.pan_angle);
        check_field("tilt_angle", want.tilt_angle, got.tilt_angle);
        check_field("min_level", want.min_level, got.min_level);
        check_field("min_pan", want.min_pan, got.min_pan);
        check_field("min_tilt", want.min_tilt, got.min_tilt);
        check_field("max_level", want.max_level, got.max_level);
        check_field("max_pan", want.max_pan, got.max_pan);
        check_field("max_tilt", want.max_tilt, got.max_tilt);
      end
    end
  end

  initial begin
    #4000000;
    $display("FAIL");
    $finish;
  end

  initial begin
    fail_count    = 0;
    items_sent    = 0;
    tx_burst_left = 0;
    tx_idle_off   = 1'b0;
    rx_stall_off  = 1'b0;
    step_deg      = STEP_RESET;
    angle_max     = LIMIT_RESET;
    s_mode        = ST_IDLE;
    s_move        = '0;
    s_pan         = '0;
    s_tilt        = '0;
    s_lo_level    = LEVEL_MAX;
    s_lo_pan      = '0;
    s_lo_tilt     = '0;
    s_hi_level    = '0;
    s_hi_pan      = '0;
    s_hi_tilt     = '0;
    rst_n       <= 1'b0;
    in_ch.valid <= 1'b0;
    in_ch.data  <= '0;
    cfg_we      <= 1'b0;
    cfg_index   <= REG_STEP;
    cfg_wdata   <= '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_idle_ops();
    test_restart_and_cancel();
    test_angle_saturation();
    test_random_scans();
    wait_results();
    repeat (4) @(posedge clk);
    if (fail_count == 0 && pending_results.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
`default_nettype wire
